/* rtl/core/cp15_system_register_transfer_top_assert.svh */
// ----------------------------------------------------------------------------
// cp15 register transfer assertion macros
// Concurrent assertion helpers, removed when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef CP15_SYSTEM_REGISTER_TRANSFER_TOP_ASSERT_SVH
`define CP15_SYSTEM_REGISTER_TRANSFER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define CP15SRT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cp15srt assertion failed");

// condition must never be seen outside reset
`define CP15SRT_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) not (cond)) \
    else $error("cp15srt forbidden condition seen");

`else

`define CP15SRT_ASSERT(name, clk, rst_n, prop)
`define CP15SRT_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

/* rtl/core/cp15srt_pkg.sv */
// ----------------------------------------------------------------------------
// cp15srt_pkg
// Shared types and constants of the cp15 register transfer block
// ----------------------------------------------------------------------------
`default_nettype none

package cp15srt_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARCH_LEVEL     = 3'd0,
    CFG_MAIN_ID        = 3'd1,
    CFG_CACHE_TYPE     = 3'd2,
    CFG_CACHE_LEVEL_ID = 3'd3,
    CFG_CACHE_SIZE_ID  = 3'd4
  } cfg_idx_e;

  // architecture level codes
  localparam logic [1:0] ARCH_V6 = 2'd1;
  localparam logic [1:0] ARCH_V7 = 2'd2;

  // primary register numbers
  localparam logic [3:0] CRN_ID    = 4'd0;
  localparam logic [3:0] CRN_CTRL  = 4'd1;
  localparam logic [3:0] CRN_TTB   = 4'd2;
  localparam logic [3:0] CRN_DAC   = 4'd3;
  localparam logic [3:0] CRN_FSR   = 4'd5;
  localparam logic [3:0] CRN_FAR   = 4'd6;
  localparam logic [3:0] CRN_CACHE = 4'd7;
  localparam logic [3:0] CRN_TLB   = 4'd8;
  localparam logic [3:0] CRN_REMAP = 4'd10;
  localparam logic [3:0] CRN_PID   = 4'd13;

  // masks for write values: pid write mask, ttbr0 alignment check
  localparam logic [DATA_W-1:0] PID_MASK       = 32'hFE00_0000;
  localparam logic [DATA_W-1:0] TTB_ALIGN_MASK = 32'h0000_3FFF;

  // one coprocessor access
  typedef struct packed {
    logic              is_read;
    logic [3:0]        crn;
    logic [2:0]        opc1;
    logic [3:0]        crm;
    logic [2:0]        opc2;
    logic [DATA_W-1:0] write_value;
    logic              table_in_ram;
  } req_t;

  // result of one access
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              undefined_fault;
    logic              context_flush;
    logic              tlb_flush_all;
    logic              control_written;
    logic              cache_op_request;
    logic              tlb_op_request;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/core/cp15srt_req_if.sv */
// ----------------------------------------------------------------------------
// cp15srt_req_if
// Valid/ready channel carrying one coprocessor access
// ----------------------------------------------------------------------------
`default_nettype none

interface cp15srt_req_if;
  import cp15srt_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* rtl/core/cp15srt_rsp_if.sv */
// ----------------------------------------------------------------------------
// cp15srt_rsp_if
// Valid/ready channel carrying one access result
// ----------------------------------------------------------------------------
`default_nettype none

interface cp15srt_rsp_if;
  import cp15srt_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* rtl/core/cp15_system_register_transfer_top.sv */
// ----------------------------------------------------------------------------
// cp15_system_register_transfer_top
// MRC / MCR register transfer unit for the system control coprocessor
// ----------------------------------------------------------------------------
// usage
//   req_i carries one access per transaction (direction, crn, opc1, crm, opc2,
//   write value, table-in-ram flag); rsp_o returns exactly one result per
//   access: read data, undefined fault and the flush / request flags.
//   cfg_we_i / cfg_idx_i / cfg_wdata_i write the identification registers
//   and the architecture level; write them only while no access is in flight.
// pipeline and throughput
//   an accepted access waits in the input register, is decoded there and
//   applied to the register file as its result is loaded into the result
//   register, from which the result is shown. one access per cycle is
//   sustained while rsp_o is not held off; the single decode stage
//   between the input register and the result register sets this figure.
// reset
//   rst_ni clears both pipeline slots, the configuration and all stored
//   system registers to zero; the block is ready right after reset.
// stall
//   while rsp_o is held off, the result register keeps its transaction and
//   one more access may enter the input register; then req_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cp15_system_register_transfer_top_assert.svh"

module cp15_system_register_transfer_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [cp15srt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cp15srt_pkg::DATA_W-1:0]     cfg_wdata_i,
  cp15srt_req_if.sink                             req_i,
  cp15srt_rsp_if.source                           rsp_o
);
  import cp15srt_pkg::*;

  // register file selector
  typedef enum logic [4:0] {
    RS_NONE,
    RS_CSSELR,
    RS_SCTLR,
    RS_ACTLR,
    RS_CPACR,
    RS_TTBR0,
    RS_TTBR1,
    RS_TTBCR,
    RS_DACR,
    RS_FSR,
    RS_FAR,
    RS_PRRR,
    RS_NMRR,
    RS_CTXID,
    RS_TID0,
    RS_TID1,
    RS_TID2,
    RS_PID
  } reg_sel_e;

  // configuration
  logic [1:0]        arch_level_q;
  logic [DATA_W-1:0] main_id_q, cache_type_q, cache_level_id_q, cache_size_id_q;

  // stored system registers
  logic [DATA_W-1:0] csselr_q, sctlr_q, actlr_q, cpacr_q;
  logic [DATA_W-1:0] ttbr0_q, ttbr1_q, ttbcr_q, dacr_q;
  logic [DATA_W-1:0] fsr_q, far_q, prrr_q, nmrr_q;
  logic [DATA_W-1:0] ctxid_q, tid0_q, tid1_q, tid2_q, pid_q;

  // pipeline
  logic s1_valid_q;
  req_t s1_q;
  logic rsp_valid_q;
  rsp_t rsp_q;
  logic s1_adv;
  logic req_hs;

  // decode results
  reg_sel_e          rs;
  logic              und;
  logic              cop;
  logic              top_req;
  logic [DATA_W-1:0] id_data;
  logic [DATA_W-1:0] rd_val;
  logic [DATA_W-1:0] wr_val;
  logic              v6, v7;
  rsp_t              rsp_d;

  // handshake
  assign s1_adv      = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign req_hs      = req_i.valid && req_i.ready;

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  assign v6 = (arch_level_q >= ARCH_V6);
  assign v7 = (arch_level_q >= ARCH_V7);

  // access decode
  always_comb begin
    rs      = RS_NONE;
    und     = 1'b0;
    cop     = 1'b0;
    top_req = 1'b0;
    id_data = '0;
    case (s1_q.crn)
      CRN_ID: begin
        if (v7 && s1_q.opc1 == 3'd1 && s1_q.crm == 4'd0 && s1_q.is_read) begin
          if (s1_q.opc2 == 3'd0) begin
            id_data = cache_size_id_q;
          end else if (s1_q.opc2 == 3'd1) begin
            id_data = cache_level_id_q;
          end else begin
            und = 1'b1;
          end
        end else if (v7 && s1_q.opc1 == 3'd2 && s1_q.crm == 4'd0 && s1_q.opc2 == 3'd0) begin
          rs = RS_CSSELR;
        end else if (s1_q.opc1 == 3'd0 && s1_q.crm == 4'd0) begin
          // id writes are dropped without a fault
          if (s1_q.opc2 > 3'd1) begin
            und = 1'b1;
          end else begin
            id_data = (s1_q.opc2 == 3'd0) ? main_id_q : cache_type_q;
          end
        end else begin
          und = 1'b1;
        end
      end
      CRN_CTRL: begin
        if (s1_q.opc2 == 3'd0) begin
          rs = RS_SCTLR;
        end else if (s1_q.opc2 == 3'd1) begin
          rs = RS_ACTLR;
        end else if (s1_q.opc2 == 3'd2 && v6 && s1_q.opc1 == 3'd0 && s1_q.crm == 4'd0) begin
          rs = RS_CPACR;
        end else begin
          und = 1'b1;
        end
      end
      CRN_TTB: begin
        if (v6 && (s1_q.opc2 == 3'd1 || s1_q.opc2 == 3'd2)) begin
          rs = (s1_q.opc2 == 3'd1) ? RS_TTBR1 : RS_TTBCR;
        end else if (s1_q.is_read) begin
          rs = RS_TTBR0;
        end else if (!v7 && (((s1_q.write_value & TTB_ALIGN_MASK) != '0) ||
                             !s1_q.table_in_ram)) begin
          und = 1'b1;
        end else begin
          rs = RS_TTBR0;
        end
      end
      CRN_DAC: begin
        // domain 0 must stay accessible
        if (!s1_q.is_read && !s1_q.write_value[0]) begin
          und = 1'b1;
        end else begin
          rs = RS_DACR;
        end
      end
      CRN_FSR:   rs = RS_FSR;
      CRN_FAR:   rs = RS_FAR;
      CRN_CACHE: cop = 1'b1;
      CRN_TLB:   top_req = 1'b1;
      CRN_REMAP: begin
        if (v6 && s1_q.opc1 == 3'd0 && s1_q.crm == 4'd2 && s1_q.opc2 <= 3'd1) begin
          rs = s1_q.opc2[0] ? RS_NMRR : RS_PRRR;
        end else begin
          und = 1'b1;
        end
      end
      CRN_PID: begin
        if (v6 && s1_q.opc2 >= 3'd1 && s1_q.opc2 <= 3'd4) begin
          case (s1_q.opc2)
            3'd1:    rs = RS_CTXID;
            3'd2:    rs = RS_TID0;
            3'd3:    rs = RS_TID1;
            default: rs = RS_TID2;
          endcase
        end else begin
          rs = RS_PID;
        end
      end
      default: und = 1'b1;
    endcase
  end

  // register file read
  always_comb begin
    case (rs)
      RS_CSSELR: rd_val = csselr_q;
      RS_SCTLR:  rd_val = sctlr_q;
      RS_ACTLR:  rd_val = actlr_q;
      RS_CPACR:  rd_val = cpacr_q;
      RS_TTBR0:  rd_val = ttbr0_q;
      RS_TTBR1:  rd_val = ttbr1_q;
      RS_TTBCR:  rd_val = ttbcr_q;
      RS_DACR:   rd_val = dacr_q;
      RS_FSR:    rd_val = fsr_q;
      RS_FAR:    rd_val = far_q;
      RS_PRRR:   rd_val = prrr_q;
      RS_NMRR:   rd_val = nmrr_q;
      RS_CTXID:  rd_val = ctxid_q;
      RS_TID0:   rd_val = tid0_q;
      RS_TID1:   rd_val = tid1_q;
      RS_TID2:   rd_val = tid2_q;
      RS_PID:    rd_val = pid_q;
      default:   rd_val = '0;
    endcase
  end

  // fcse pid keeps only its top bits
  assign wr_val = (rs == RS_PID) ? (s1_q.write_value & PID_MASK) : s1_q.write_value;

  // result assembly
  always_comb begin
    rsp_d                  = '0;
    rsp_d.undefined_fault  = und;
    rsp_d.cache_op_request = cop;
    rsp_d.tlb_op_request   = top_req;
    if (s1_q.is_read && !und) begin
      rsp_d.read_data = (rs != RS_NONE) ? rd_val : id_data;
    end
    if (!s1_q.is_read) begin
      rsp_d.context_flush   = (rs == RS_TTBR0 || rs == RS_CTXID || rs == RS_PID) &&
                              (rd_val != wr_val);
      rsp_d.tlb_flush_all   = (rs == RS_DACR);
      rsp_d.control_written = (rs == RS_SCTLR);
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_hs) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (req_hs) begin
      s1_q <= req_i.payload;
    end
    if (s1_adv) begin
      rsp_q <= rsp_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_level_q     <= '0;
      main_id_q        <= '0;
      cache_type_q     <= '0;
      cache_level_id_q <= '0;
      cache_size_id_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ARCH_LEVEL:     arch_level_q     <= cfg_wdata_i[1:0];
        CFG_MAIN_ID:        main_id_q        <= cfg_wdata_i;
        CFG_CACHE_TYPE:     cache_type_q     <= cfg_wdata_i;
        CFG_CACHE_LEVEL_ID: cache_level_id_q <= cfg_wdata_i;
        CFG_CACHE_SIZE_ID:  cache_size_id_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // system register file update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csselr_q <= '0;
      sctlr_q  <= '0;
      actlr_q  <= '0;
      cpacr_q  <= '0;
      ttbr0_q  <= '0;
      ttbr1_q  <= '0;
      ttbcr_q  <= '0;
      dacr_q   <= '0;
      fsr_q    <= '0;
      far_q    <= '0;
      prrr_q   <= '0;
      nmrr_q   <= '0;
      ctxid_q  <= '0;
      tid0_q   <= '0;
      tid1_q   <= '0;
      tid2_q   <= '0;
      pid_q    <= '0;
    end else if (s1_adv && !s1_q.is_read) begin
      case (rs)
        RS_CSSELR: csselr_q <= wr_val;
        RS_SCTLR:  sctlr_q  <= wr_val;
        RS_ACTLR:  actlr_q  <= wr_val;
        RS_CPACR:  cpacr_q  <= wr_val;
        RS_TTBR0:  ttbr0_q  <= wr_val;
        RS_TTBR1:  ttbr1_q  <= wr_val;
        RS_TTBCR:  ttbcr_q  <= wr_val;
        RS_DACR:   dacr_q   <= wr_val;
        RS_FSR:    fsr_q    <= wr_val;
        RS_FAR:    far_q    <= wr_val;
        RS_PRRR:   prrr_q   <= wr_val;
        RS_NMRR:   nmrr_q   <= wr_val;
        RS_CTXID:  ctxid_q  <= wr_val;
        RS_TID0:   tid0_q   <= wr_val;
        RS_TID1:   tid1_q   <= wr_val;
        RS_TID2:   tid2_q   <= wr_val;
        RS_PID:    pid_q    <= wr_val;
        default: ;
      endcase
    end
  end

  // assertions
  `CP15SRT_ASSERT(a_und_quiet, clk_i, rst_ni, rsp_valid_q && rsp_q.undefined_fault |-> !rsp_q.context_flush && !rsp_q.tlb_flush_all && !rsp_q.control_written && !rsp_q.cache_op_request && !rsp_q.tlb_op_request && rsp_q.read_data == '0)
  `CP15SRT_ASSERT(a_write_no_data, clk_i, rst_ni, s1_adv && !s1_q.is_read |=> rsp_q.read_data == '0)
  `CP15SRT_ASSERT(a_adv_shows_result, clk_i, rst_ni, s1_adv |=> rsp_valid_q)
  `CP15SRT_ASSERT(a_dacr_domain0, clk_i, rst_ni, dacr_q[0] || dacr_q == '0)
  `CP15SRT_ASSERT_NEVER(a_pid_low_bits, clk_i, rst_ni, (pid_q & ~PID_MASK) != '0)

endmodule

`default_nettype wire

/* bench/cp15srt_checker.sv */
// ----------------------------------------------------------------------------
// cp15srt_checker
// Watches the access and result channels of the cp15 register transfer
// block, keeps a shadow of its system registers and configuration,
// predicts the result of every accepted access and compares each
// accepted result field by field against the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module cp15srt_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [2:0]                   cfg_idx_i,
  input  wire logic [31:0]                  cfg_wdata_i,
  input  wire logic                         req_valid_i,
  input  wire logic                         req_ready_i,
  input  wire cp15srt_pkg::req_t            req_payload_i,
  input  wire logic                         rsp_valid_i,
  input  wire logic                         rsp_ready_i,
  input  wire cp15srt_pkg::rsp_t            rsp_payload_i,
  output int unsigned                       pending_o,
  output int unsigned                       mismatch_count_o,
  output int unsigned                       checked_count_o,
  output int unsigned                       fault_count_o,
  output int unsigned                       flush_count_o
);
  import cp15srt_pkg::*;

  // registers reached by a plain read or write
  typedef enum int {
    SEL_NONE, SEL_CSSELR, SEL_ACTLR, SEL_CPACR, SEL_TTBR1, SEL_TTBCR,
    SEL_FSR, SEL_FAR, SEL_PRRR, SEL_NMRR, SEL_TID0, SEL_TID1, SEL_TID2,
    SEL_COUNT
  } plain_sel_e;

  localparam int unsigned MAX_PRINTED = 100;

  // shadow configuration
  logic [1:0]  arch_level;
  logic [31:0] main_id, cache_type, cache_level_id, cache_size_id;

  // shadow system registers
  logic [31:0] system_control, table_base0, domain_access, context_id, fcse_pid;
  logic [31:0] plain_regs [SEL_COUNT];

  // predicted results, oldest first
  rsp_t expected_results_q [$];

  // one report line per mismatch, the first ones printed, all counted
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count_o < MAX_PRINTED)
      $display("mismatch at result %0d: %s got %h want %h",
               checked_count_o, what, got, want);
    mismatch_count_o++;
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // executes one access on the shadow state and returns its result
  function automatic rsp_t exec_cp15_access(input req_t a);
    rsp_t       r;
    plain_sel_e sel;
    logic       v6, v7, rd;
    r   = '0;
    sel = SEL_NONE;
    v6  = (arch_level >= ARCH_V6);
    v7  = (arch_level >= ARCH_V7);
    rd  = a.is_read;
    case (a.crn)
      // identification space
      CRN_ID: begin
        if (v7 && a.opc1 == 3'd1 && a.crm == 4'd0 && rd) begin
          if (a.opc2 == 3'd0) r.read_data = cache_size_id;
          else if (a.opc2 == 3'd1) r.read_data = cache_level_id;
          else r.undefined_fault = 1'b1;
        end else if (v7 && a.opc1 == 3'd2 && a.crm == 4'd0 && a.opc2 == 3'd0) begin
          sel = SEL_CSSELR;
        end else if (a.opc1 == 3'd0 && a.crm == 4'd0) begin
          // midr / ctr writes are dropped without a fault
          if (a.opc2 > 3'd1) r.undefined_fault = 1'b1;
          else if (rd) r.read_data = (a.opc2 == 3'd0) ? main_id : cache_type;
        end else begin
          r.undefined_fault = 1'b1;
        end
      end
      // control registers
      CRN_CTRL: begin
        if (a.opc2 == 3'd0) begin
          if (rd) r.read_data = system_control;
          else begin
            system_control    = a.write_value;
            r.control_written = 1'b1;
          end
        end else if (a.opc2 == 3'd1) begin
          sel = SEL_ACTLR;
        end else if (a.opc2 == 3'd2 && v6 && a.opc1 == 3'd0 && a.crm == 4'd0) begin
          sel = SEL_CPACR;
        end else begin
          r.undefined_fault = 1'b1;
        end
      end
      // translation table base, checked before v7
      CRN_TTB: begin
        if (v6 && (a.opc2 == 3'd1 || a.opc2 == 3'd2)) begin
          sel = (a.opc2 == 3'd1) ? SEL_TTBR1 : SEL_TTBCR;
        end else if (rd) begin
          r.read_data = table_base0;
        end else if (!v7 && ((a.write_value & TTB_ALIGN_MASK) != '0 || !a.table_in_ram)) begin
          r.undefined_fault = 1'b1;
        end else begin
          r.context_flush = (table_base0 != a.write_value);
          table_base0     = a.write_value;
        end
      end
      // domain access, bit 0 must be set on write
      CRN_DAC: begin
        if (rd) r.read_data = domain_access;
        else if (!a.write_value[0]) r.undefined_fault = 1'b1;
        else begin
          domain_access   = a.write_value;
          r.tlb_flush_all = 1'b1;
        end
      end
      CRN_FSR:   sel = SEL_FSR;
      CRN_FAR:   sel = SEL_FAR;
      CRN_CACHE: r.cache_op_request = 1'b1;
      CRN_TLB:   r.tlb_op_request = 1'b1;
      // memory region remap
      CRN_REMAP: begin
        if (v6 && a.opc1 == 3'd0 && a.crm == 4'd2 && a.opc2 <= 3'd1)
          sel = a.opc2[0] ? SEL_NMRR : SEL_PRRR;
        else r.undefined_fault = 1'b1;
      end
      // process and thread ids
      CRN_PID: begin
        if (v6 && a.opc2 >= 3'd1 && a.opc2 <= 3'd4) begin
          if (a.opc2 == 3'd1) begin
            if (rd) r.read_data = context_id;
            else begin
              r.context_flush = (context_id != a.write_value);
              context_id      = a.write_value;
            end
          end else begin
            case (a.opc2)
              3'd2:    sel = SEL_TID0;
              3'd3:    sel = SEL_TID1;
              default: sel = SEL_TID2;
            endcase
          end
        end else if (rd) begin
          r.read_data = fcse_pid;
        end else begin
          r.context_flush = (fcse_pid != (a.write_value & PID_MASK));
          fcse_pid        = a.write_value & PID_MASK;
        end
      end
      default: r.undefined_fault = 1'b1;
    endcase
    // plain register file
    if (sel != SEL_NONE) begin
      if (rd) r.read_data = plain_regs[sel];
      else plain_regs[sel] = a.write_value;
    end
    if (r.undefined_fault || !rd) r.read_data = '0;
    return r;
  endfunction

  // shadow update, prediction and comparison
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    rsp_t got;
    if (!rst_ni) begin
      arch_level     = '0;
      main_id        = '0;
      cache_type     = '0;
      cache_level_id = '0;
      cache_size_id  = '0;
      system_control = '0;
      table_base0    = '0;
      domain_access  = '0;
      context_id     = '0;
      fcse_pid       = '0;
      for (int i = 0; i < SEL_COUNT; i++) plain_regs[i] = '0;
      expected_results_q.delete();
      pending_o        = 0;
      mismatch_count_o = 0;
      checked_count_o  = 0;
      fault_count_o    = 0;
      flush_count_o    = 0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ARCH_LEVEL:     arch_level     = cfg_wdata_i[1:0];
          CFG_MAIN_ID:        main_id        = cfg_wdata_i;
          CFG_CACHE_TYPE:     cache_type     = cfg_wdata_i;
          CFG_CACHE_LEVEL_ID: cache_level_id = cfg_wdata_i;
          CFG_CACHE_SIZE_ID:  cache_size_id  = cfg_wdata_i;
          default: ;
        endcase
      end
      // result transaction against the oldest prediction
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_results_q.size() == 0) begin
          report_mismatch("result with no access pending", rsp_payload_i.read_data, '0);
        end else begin
          want = expected_results_q.pop_front();
          got  = rsp_payload_i;
          compare_field("read_data", got.read_data, want.read_data);
          compare_field("undefined_fault", 32'(got.undefined_fault),
                        32'(want.undefined_fault));
          compare_field("context_flush", 32'(got.context_flush), 32'(want.context_flush));
          compare_field("tlb_flush_all", 32'(got.tlb_flush_all), 32'(want.tlb_flush_all));
          compare_field("control_written", 32'(got.control_written),
                        32'(want.control_written));
          compare_field("cache_op_request", 32'(got.cache_op_request),
                        32'(want.cache_op_request));
          compare_field("tlb_op_request", 32'(got.tlb_op_request),
                        32'(want.tlb_op_request));
          checked_count_o++;
        end
      end
      // access transaction
      if (req_valid_i && req_ready_i) begin
        want = exec_cp15_access(req_payload_i);
        if (want.undefined_fault) fault_count_o++;
        if (want.context_flush) flush_count_o++;
        expected_results_q.push_back(want);
      end
      pending_o = expected_results_q.size();
    end
  end

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench top of the cp15 register transfer block: drives directed and
// random coprocessor accesses in bursts through several architecture and
// identification settings, stalls the result side on a changing pattern,
// and gives the verdict from the failure count of the checker
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import cp15srt_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned NUM_PHASES     = 6;
  localparam int unsigned RAND_PER_PHASE = 108;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES  = 4;

  localparam logic [1:0] ARCH_PRE_V6 = 2'd0;
  localparam logic [1:0] ARCH_V7_ALT = 2'd3;

  // architecture level of each phase
  localparam logic [1:0] PHASE_ARCH [NUM_PHASES] =
    '{ARCH_PRE_V6, ARCH_V7, ARCH_V6, ARCH_V7_ALT, ARCH_PRE_V6, ARCH_V7};

  // primary numbers with nothing behind them
  localparam logic [3:0] UNUSED_CRN [6] = '{4'd4, 4'd9, 4'd11, 4'd12, 4'd14, 4'd15};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  int unsigned pending, mismatch_count, checked_count, fault_count, flush_count;
  int unsigned burst_left = 1;
  int unsigned quiet_cycles;
  logic [31:0] last_wvalue = '0;

  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  logic [7:0]  stall_tick = '0;

  cp15srt_req_if req_if ();
  cp15srt_rsp_if rsp_if ();

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  cp15_system_register_transfer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  cp15srt_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_valid_i      (req_if.valid),
    .req_ready_i      (req_if.ready),
    .req_payload_i    (req_if.payload),
    .rsp_valid_i      (rsp_if.valid),
    .rsp_ready_i      (rsp_if.ready),
    .rsp_payload_i    (rsp_if.payload),
    .pending_o        (pending),
    .mismatch_count_o (mismatch_count),
    .checked_count_o  (checked_count),
    .fault_count_o    (fault_count),
    .flush_count_o    (flush_count)
  );

  // result side back-pressure, mode re-chosen at random whenever its countdown runs out
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 8'd1;
    case (stall_mode)
      0:       rsp_if.ready <= 1'b1;
      1:       rsp_if.ready <= (stall_tick[1:0] != 2'b11);
      2:       rsp_if.ready <= 1'($urandom_range(0, 1));
      default: rsp_if.ready <= (stall_tick[2:0] == 3'b000);
    endcase
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               quiet_cycles, pending);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t make_access(input logic rd, input logic [3:0] crn,
                                       input logic [2:0] opc1, input logic [3:0] crm,
                                       input logic [2:0] opc2, input logic [31:0] wv,
                                       input logic in_ram);
    req_t a;
    a.is_read      = rd;
    a.crn          = crn;
    a.opc1         = opc1;
    a.crm          = crm;
    a.opc2         = opc2;
    a.write_value  = wv;
    a.table_in_ram = in_ram;
    return a;
  endfunction

  // random access, mostly aimed at implemented encodings
  function automatic req_t gen_access();
    req_t        a;
    logic [31:0] wv;
    int unsigned enc;
    a.is_read      = 1'($urandom_range(0, 1));
    a.crn          = 4'($urandom());
    a.opc1         = 3'($urandom());
    a.crm          = 4'($urandom());
    a.opc2         = 3'($urandom());
    a.table_in_ram = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 3))
      0:       wv = last_wvalue;
      1:       wv = $urandom() & ~TTB_ALIGN_MASK;
      default: wv = $urandom();
    endcase
    if ($urandom_range(0, 3) != 0) begin
      enc = $urandom_range(0, 17);
      case (enc)
        0:  begin a.crn = CRN_ID; a.opc1 = 3'd0; a.crm = 4'd0;
                  a.opc2 = 3'($urandom_range(0, 2)); end
        1:  begin a.crn = CRN_ID; a.opc1 = 3'd1; a.crm = 4'd0;
                  a.opc2 = 3'($urandom_range(0, 2)); end
        2:  begin a.crn = CRN_ID; a.opc1 = 3'd2; a.crm = 4'd0; a.opc2 = 3'd0; end
        3:  begin a.crn = CRN_CTRL; a.opc2 = 3'd0; end
        4:  begin a.crn = CRN_CTRL; a.opc2 = 3'd1; end
        5:  begin a.crn = CRN_CTRL; a.opc1 = 3'd0; a.crm = 4'd0; a.opc2 = 3'd2; end
        6:  begin a.crn = CRN_TTB;
                  a.opc2 = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(3, 7)) : 3'd0; end
        7:  begin a.crn = CRN_TTB; a.opc2 = 3'($urandom_range(1, 2)); end
        8:  begin a.crn = CRN_DAC; wv[0] = ($urandom_range(0, 3) != 0); end
        9:  a.crn = CRN_FSR;
        10: a.crn = CRN_FAR;
        11: a.crn = CRN_CACHE;
        12: a.crn = CRN_TLB;
        13: begin a.crn = CRN_REMAP; a.opc1 = 3'd0; a.crm = 4'd2;
                  a.opc2 = 3'($urandom_range(0, 1)); end
        14: begin a.crn = CRN_PID; a.opc2 = 3'd1; end
        15: begin a.crn = CRN_PID; a.opc2 = 3'($urandom_range(2, 4)); end
        16: begin a.crn = CRN_PID;
                  a.opc2 = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(5, 7)); end
        default: a.crn = UNUSED_CRN[$urandom_range(0, 5)];
      endcase
    end
    a.write_value = wv;
    if (!a.is_read) last_wvalue = wv;
    return a;
  endfunction

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
  endtask

  // one access transaction, then a random gap at the end of a burst
  task automatic send_access(input req_t a);
    @(negedge clk_i);
    req_if.valid   <= 1'b1;
    req_if.payload <= a;
    do @(posedge clk_i); while (!req_if.ready);
    burst_left--;
    if (burst_left == 0) begin
      idle_cycles($urandom_range(1, 10));
      burst_left = $urandom_range(1, 30);
    end
  endtask

  // hold off until every result has come back
  task automatic drain();
    idle_cycles(1);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
  endtask

  // architecture level and identification values of one phase
  task automatic load_config(input int unsigned phase);
    logic [31:0] arch_word;
    arch_word = $urandom();
    arch_word[1:0] = PHASE_ARCH[phase];
    cfg_write(CFG_ARCH_LEVEL, arch_word);
    case (phase)
      0: begin
        cfg_write(CFG_MAIN_ID, 32'hFFFF_FFFF);
        cfg_write(CFG_CACHE_TYPE, 32'h0000_0000);
        cfg_write(CFG_CACHE_LEVEL_ID, 32'hFFFF_FFFF);
        cfg_write(CFG_CACHE_SIZE_ID, 32'h0000_0000);
      end
      1: begin
        cfg_write(CFG_MAIN_ID, 32'h0000_0000);
        cfg_write(CFG_CACHE_TYPE, 32'hFFFF_FFFF);
        cfg_write(CFG_CACHE_LEVEL_ID, 32'h0000_0000);
        cfg_write(CFG_CACHE_SIZE_ID, 32'hFFFF_FFFF);
      end
      default: begin
        cfg_write(CFG_MAIN_ID, $urandom());
        cfg_write(CFG_CACHE_TYPE, $urandom());
        cfg_write(CFG_CACHE_LEVEL_ID, $urandom());
        cfg_write(CFG_CACHE_SIZE_ID, $urandom());
      end
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // directed accesses before v6: id reads, checks on ttbr0, dacr and pid
  task automatic run_directed_pre_v6();
    send_access(make_access(1'b1, CRN_ID, 3'd0, 4'd0, 3'd0, '0, 1'b1));
    send_access(make_access(1'b1, CRN_ID, 3'd0, 4'd0, 3'd1, '0, 1'b1));
    // identification writes are dropped silently
    send_access(make_access(1'b0, CRN_ID, 3'd0, 4'd0, 3'd0, 32'hFFFF_FFFF, 1'b1));
    send_access(make_access(1'b1, CRN_ID, 3'd0, 4'd0, 3'd7, '0, 1'b0));
    send_access(make_access(1'b0, CRN_CTRL, 3'd7, 4'd15, 3'd0, 32'hFFFF_FFFF, 1'b1));
    send_access(make_access(1'b1, CRN_CTRL, 3'd0, 4'd0, 3'd0, '0, 1'b1));
    // misaligned base, then base outside ram
    send_access(make_access(1'b0, CRN_TTB, 3'd0, 4'd0, 3'd0, 32'h0000_0001, 1'b1));
    send_access(make_access(1'b0, CRN_TTB, 3'd0, 4'd0, 3'd0, 32'hFFFF_C000, 1'b0));
    // good base twice: flush only on the change
    send_access(make_access(1'b0, CRN_TTB, 3'd0, 4'd0, 3'd0, 32'hFFFF_C000, 1'b1));
    send_access(make_access(1'b0, CRN_TTB, 3'd0, 4'd0, 3'd0, 32'hFFFF_C000, 1'b1));
    send_access(make_access(1'b1, CRN_TTB, 3'd0, 4'd0, 3'd0, '0, 1'b1));
    send_access(make_access(1'b0, CRN_DAC, 3'd0, 4'd0, 3'd0, 32'hFFFF_FFFE, 1'b1));
    send_access(make_access(1'b0, CRN_DAC, 3'd0, 4'd0, 3'd0, 32'h0000_0001, 1'b1));
    send_access(make_access(1'b1, CRN_DAC, 3'd0, 4'd0, 3'd0, '0, 1'b1));
    // pid keeps its top seven bits only
    send_access(make_access(1'b0, CRN_PID, 3'd0, 4'd0, 3'd0, 32'hFFFF_FFFF, 1'b1));
    send_access(make_access(1'b1, CRN_PID, 3'd0, 4'd0, 3'd0, '0, 1'b1));
    send_access(make_access(1'b1, CRN_CACHE, 3'd7, 4'd15, 3'd7, '0, 1'b1));
    send_access(make_access(1'b0, CRN_TLB, 3'd0, 4'd7, 3'd0, 32'hFFFF_FFFF, 1'b1));
    send_access(make_access(1'b1, UNUSED_CRN[5], 3'd0, 4'd0, 3'd0, '0, 1'b1));
    send_access(make_access(1'b1, CRN_REMAP, 3'd0, 4'd2, 3'd0, '0, 1'b1));
  endtask

  // directed accesses under v7: cache id, selection, unchecked ttbr0, ids
  task automatic run_directed_v7();
    send_access(make_access(1'b1, CRN_ID, 3'd1, 4'd0, 3'd0, '0, 1'b1));
    send_access(make_access(1'b1, CRN_ID, 3'd1, 4'd0, 3'd1, '0, 1'b1));
    send_access(make_access(1'b0, CRN_ID, 3'd2, 4'd0, 3'd0, 32'hFFFF_FFFF, 1'b1));
    send_access(make_access(1'b1, CRN_ID, 3'd2, 4'd0, 3'd0, '0, 1'b1));
    send_access(make_access(1'b0, CRN_TTB, 3'd0, 4'd0, 3'd0, 32'h0000_0001, 1'b0));
    // thread id writes never flush
    send_access(make_access(1'b0, CRN_PID, 3'd0, 4'd0, 3'd4, 32'hFFFF_FFFF, 1'b1));
    send_access(make_access(1'b0, CRN_PID, 3'd0, 4'd0, 3'd1, 32'hFFFF_FFFF, 1'b1));
  endtask

  // stimulus and verdict
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_ARCH_LEVEL;
    cfg_wdata_i    = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      load_config(phase);
      if (phase == 0) run_directed_pre_v6();
      if (phase == 1) run_directed_v7();
      repeat (RAND_PER_PHASE) send_access(gen_access());
    end
    drain();

    $display("checked %0d accesses over %0d configuration phases at all four arch codes",
             checked_count, NUM_PHASES);
    $display("predicted %0d undefined faults and %0d context flushes",
             fault_count, flush_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
